>>> hw/rtl/abkf_pkg.sv
// shared types, constants and saturation helper for the angle/bias kalman filter
// no dependencies; imported by abkf_div, angle_bias_kalman_filter and the testbench
`default_nettype none

package abkf_pkg;

  // register indexes on the configuration channel
  localparam logic [1:0] RegAngleNoise = 2'd0;
  localparam logic [1:0] RegBiasNoise  = 2'd1;
  localparam logic [1:0] RegMeasNoise  = 2'd2;
  localparam logic [1:0] RegTimeStep   = 2'd3;

  // reset values of the registers, q2.30
  localparam logic [30:0] AngleNoiseRst = 31'd5368709;
  localparam logic [30:0] BiasNoiseRst  = 31'd8589935;
  localparam logic [30:0] MeasNoiseRst  = 31'd161061;
  localparam logic [30:0] TimeStepRst   = 31'd8589935;

  localparam logic signed [31:0] OneQ30 = 32'sh4000_0000;

  // quotient bits produced by the divider (dividend is a 32-bit value shifted up by 30)
  localparam int unsigned DivSteps = 62;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RATE,
    ST_M_ANG,
    ST_A_ANG,
    ST_P0,
    ST_M_AA,
    ST_A_AA,
    ST_M_OFF,
    ST_A_OFF,
    ST_M_BB,
    ST_A_BB,
    ST_GAIN,
    ST_DS0,
    ST_DIV_K0,
    ST_DS1,
    ST_DIV_K1,
    ST_M_BA2,
    ST_A_BA2,
    ST_M_BB2,
    ST_A_BB2,
    ST_M_AA2,
    ST_A_AA2,
    ST_M_AB2,
    ST_A_AB2,
    ST_ERR,
    ST_M_ANG2,
    ST_A_ANG2,
    ST_M_BIAS,
    ST_A_BIAS,
    ST_DONE
  } abkf_state_e;

  // clamp a 36-bit signed sum to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/angle_bias_kalman_filter.sv
// angle/bias kalman filter: one transaction in, one result out, per-axis state kept inside
// a non-positive innovation variance skips both gain divisions (gains zero); an
// out-of-range axis goes straight to a zero result; the two gains come from the
// bit-serial divider, and every multiply runs on the one shared multiplier.
// takes no new transaction while an item is worked or its result waits.
// reset (async, active low): per-axis state to zero, p diagonal to 1.0, register defaults
// depends on abkf_pkg, abkf_mul, abkf_div
`default_nettype none

module angle_bias_kalman_filter #(
  parameter int NUM_AXES = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // measured_angle[24:0], gyro_rate[52:25], zero pad
  input  wire logic        s_axis_tuser,  // axis_select
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // angle_estimate[31:0], unbiased_rate[63:32]
  output logic             m_axis_tuser,  // out_axis
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [30:0] cfg_data_i
);
  import abkf_pkg::*;

  localparam int IdxW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  abkf_state_e state_q, state_d;

  // configuration registers
  logic [30:0] apn_q, bpn_q, mn_q, dt_q;

  // per-axis state
  logic signed [31:0] st_ang_q [NUM_AXES];
  logic signed [31:0] st_bias_q[NUM_AXES];
  logic signed [31:0] st_aa_q  [NUM_AXES];
  logic signed [31:0] st_ab_q  [NUM_AXES];
  logic signed [31:0] st_ba_q  [NUM_AXES];
  logic signed [31:0] st_bb_q  [NUM_AXES];

  // working registers
  logic signed [31:0] ang_q, bias_q, aa_q, ab_q, ba_q, bb_q, k0_q, k1_q, tmp_q;
  logic signed [24:0] meas_q;
  logic signed [27:0] rate_q;
  logic [32:0]        e_q;
  logic               axis_q, axis_ok_q;
  logic [IdxW-1:0]    idx_q;

  logic               m_valid_q, m_user_q;
  logic [63:0]        m_data_q;

  logic               in_axis_ok;
  logic [IdxW-1:0]    in_idx;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [33:0] mp;
  logic               div_start, div_done;
  logic signed [31:0] div_num, div_quo;
  logic signed [35:0] e_sum;
  logic               out_free;

  assign in_axis_ok = 32'(s_axis_tuser) < NUM_AXES;
  assign in_idx     = IdxW'(s_axis_tuser);
  assign mp         = mul_p[63:30];
  assign e_sum      = 36'(signed'({1'b0, mn_q})) + 36'(aa_q);
  assign out_free   = !m_valid_q || m_axis_tready;

  abkf_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_p)
  );

  abkf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (e_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (s_axis_tvalid) state_d = in_axis_ok ? ST_RATE : ST_DONE;
      ST_RATE:   state_d = ST_M_ANG;
      ST_M_ANG:  state_d = ST_A_ANG;
      ST_A_ANG:  state_d = ST_P0;
      ST_P0:     state_d = ST_M_AA;
      ST_M_AA:   state_d = ST_A_AA;
      ST_A_AA:   state_d = ST_M_OFF;
      ST_M_OFF:  state_d = ST_A_OFF;
      ST_A_OFF:  state_d = ST_M_BB;
      ST_M_BB:   state_d = ST_A_BB;
      ST_A_BB:   state_d = ST_GAIN;
      ST_GAIN:   state_d = (e_sum > 36'sd0) ? ST_DS0 : ST_M_BA2;
      ST_DS0:    state_d = ST_DIV_K0;
      ST_DIV_K0: if (div_done) state_d = ST_DS1;
      ST_DS1:    state_d = ST_DIV_K1;
      ST_DIV_K1: if (div_done) state_d = ST_M_BA2;
      ST_M_BA2:  state_d = ST_A_BA2;
      ST_A_BA2:  state_d = ST_M_BB2;
      ST_M_BB2:  state_d = ST_A_BB2;
      ST_A_BB2:  state_d = ST_M_AA2;
      ST_M_AA2:  state_d = ST_A_AA2;
      ST_A_AA2:  state_d = ST_M_AB2;
      ST_M_AB2:  state_d = ST_A_AB2;
      ST_A_AB2:  state_d = ST_ERR;
      ST_ERR:    state_d = ST_M_ANG2;
      ST_M_ANG2: state_d = ST_A_ANG2;
      ST_A_ANG2: state_d = ST_M_BIAS;
      ST_M_BIAS: state_d = ST_A_BIAS;
      ST_A_BIAS: state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands, divider start
  always_comb begin
    s_axis_tready = 1'b0;
    mul_a         = tmp_q;
    mul_b         = signed'({1'b0, dt_q});
    div_start     = 1'b0;
    div_num       = aa_q;
    case (state_q)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_M_OFF:  mul_a = bb_q;
      ST_M_BB:   mul_a = signed'({1'b0, bpn_q});
      ST_DS0:    div_start = 1'b1;
      ST_DS1: begin
        div_start = 1'b1;
        div_num   = ba_q;
      end
      ST_M_BA2: begin
        mul_a = k1_q;
        mul_b = aa_q;
      end
      ST_M_BB2: begin
        mul_a = k1_q;
        mul_b = ab_q;
      end
      ST_M_AA2: begin
        mul_a = k0_q;
        mul_b = aa_q;
      end
      ST_M_AB2: begin
        mul_a = k0_q;
        mul_b = ab_q;
      end
      ST_M_ANG2: mul_b = k0_q;
      ST_M_BIAS: mul_b = k1_q;
      default: ;
    endcase
  end

  // state register, configuration, per-axis state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      apn_q     <= AngleNoiseRst;
      bpn_q     <= BiasNoiseRst;
      mn_q      <= MeasNoiseRst;
      dt_q      <= TimeStepRst;
      for (int i = 0; i < NUM_AXES; i++) begin
        st_ang_q[i]  <= '0;
        st_bias_q[i] <= '0;
        st_aa_q[i]   <= OneQ30;
        st_ab_q[i]   <= '0;
        st_ba_q[i]   <= '0;
        st_bb_q[i]   <= OneQ30;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegAngleNoise: apn_q <= cfg_data_i;
          RegBiasNoise:  bpn_q <= cfg_data_i;
          RegMeasNoise:  mn_q  <= cfg_data_i;
          RegTimeStep:   dt_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
        if (axis_ok_q) begin
          st_ang_q[idx_q]  <= ang_q;
          st_bias_q[idx_q] <= bias_q;
          st_aa_q[idx_q]   <= aa_q;
          st_ab_q[idx_q]   <= ab_q;
          st_ba_q[idx_q]   <= ba_q;
          st_bb_q[idx_q]   <= bb_q;
        end
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // working datapath: axis state load, saturating add steps, gain capture and output register
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          axis_q    <= s_axis_tuser;
          axis_ok_q <= in_axis_ok;
          idx_q     <= in_idx;
          meas_q    <= s_axis_tdata[24:0];
          rate_q    <= s_axis_tdata[52:25];
          if (in_axis_ok) begin
            ang_q  <= st_ang_q[in_idx];
            bias_q <= st_bias_q[in_idx];
            aa_q   <= st_aa_q[in_idx];
            ab_q   <= st_ab_q[in_idx];
            ba_q   <= st_ba_q[in_idx];
            bb_q   <= st_bb_q[in_idx];
          end
        end
      end
      ST_RATE:   tmp_q <= sat32(36'(rate_q) - 36'(bias_q));
      ST_A_ANG:  ang_q <= sat32(36'(ang_q) + 36'(mp));
      ST_P0:     tmp_q <= sat32(36'(signed'({1'b0, apn_q})) - 36'(ab_q) - 36'(ba_q));
      ST_A_AA:   aa_q  <= sat32(36'(aa_q) + 36'(mp));
      ST_A_OFF: begin
        ab_q <= sat32(36'(ab_q) - 36'(mp));
        ba_q <= sat32(36'(ba_q) - 36'(mp));
      end
      ST_A_BB:   bb_q  <= sat32(36'(bb_q) + 36'(mp));
      ST_GAIN: begin
        e_q  <= e_sum[32:0];
        k0_q <= '0;
        k1_q <= '0;
      end
      ST_DIV_K0: if (div_done) k0_q <= div_quo;
      ST_DIV_K1: if (div_done) k1_q <= div_quo;
      ST_A_BA2:  ba_q  <= sat32(36'(ba_q) - 36'(mp));
      ST_A_BB2:  bb_q  <= sat32(36'(bb_q) - 36'(mp));
      ST_A_AA2:  aa_q  <= sat32(36'(aa_q) - 36'(mp));
      ST_A_AB2:  ab_q  <= sat32(36'(ab_q) - 36'(mp));
      ST_ERR:    tmp_q <= sat32(36'(meas_q) - 36'(ang_q));
      ST_A_ANG2: ang_q <= sat32(36'(ang_q) + 36'(mp));
      ST_A_BIAS: bias_q <= sat32(36'(bias_q) + 36'(mp));
      ST_DONE: begin
        if (out_free) begin
          m_user_q <= axis_q;
          if (axis_ok_q) begin
            m_data_q <= {sat32(36'(rate_q) - 36'(bias_q)), ang_q};
          end else begin
            m_data_q <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

>>> hw/rtl/abkf_mul.sv
// shared 32x32 signed multiplier with a registered 64-bit product
// no dependencies
`default_nettype none

module abkf_mul (
  input  wire logic               clk_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  output logic signed [63:0]      prod_o
);

  logic signed [63:0] prod_q;

  // product register
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

>>> hw/rtl/abkf_div.sv
// bit-serial restoring divider: sat32((num * 2^30) / den), truncated toward zero
// depends on abkf_pkg; den must be positive
`default_nettype none

module abkf_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] num_i,
  input  wire logic        [32:0] den_i,
  output logic                    done_o,
  output logic signed [31:0]      quo_o
);
  import abkf_pkg::*;

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [33:0] rem_q;
  logic [61:0] dvd_q, quo_q;
  logic [32:0] den_q;
  logic        neg_q;
  logic [33:0] rem_sh, rem_nx;
  logic        fits;
  logic [31:0] mag;

  // one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q[32:0], dvd_q[61]};
    fits   = rem_sh >= {1'b0, den_q};
    rem_nx = fits ? rem_sh - {1'b0, den_q} : rem_sh;
    mag    = num_i[31] ? (~num_i + 32'd1) : num_i;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      dvd_q <= {mag, 30'b0};
      quo_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[31];
    end else if (busy_q) begin
      rem_q <= rem_nx;
      dvd_q <= {dvd_q[60:0], 1'b0};
      quo_q <= {quo_q[60:0], fits};
    end
  end

  // sign and saturation of the quotient
  always_comb begin
    if (neg_q) begin
      if (quo_q[61:32] != '0 || (quo_q[31] && quo_q[30:0] != '0)) begin
        quo_o = 32'sh8000_0000;
      end else begin
        quo_o = ~quo_q[31:0] + 32'd1;
      end
    end else begin
      if (quo_q[61:31] != '0) begin
        quo_o = 32'sh7FFF_FFFF;
      end else begin
        quo_o = quo_q[31:0];
      end
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

>>> tb/angle_bias_kalman_filter_tb.sv
// testbench for angle_bias_kalman_filter: streams tilt samples, predicts each fused result
// with an in-bench fixed-point filter model; depends on abkf_pkg and the rtl
`timescale 1ns / 1ps

module angle_bias_kalman_filter_tb;
  import abkf_pkg::*;

  typedef struct packed {
    logic        axis;
    logic [31:0] angle;
    logic [31:0] rate;
  } fused_t;

  localparam int NumAxes = 2;
  localparam int StallLimit = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [63:0] m_axis_tdata;
  wire         m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  wire         cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [30:0] cfg_data_i = '0;

  angle_bias_kalman_filter #(.NUM_AXES(NumAxes)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // filter model state
  longint ang_q[NumAxes], bias_q[NumAxes];
  longint paa[NumAxes], pab[NumAxes], pba[NumAxes], pbb[NumAxes];
  longint q_angle, q_bias, r_meas, dt_q;

  fused_t fused_expected[$];
  int     errors = 0;
  bit     calm = 0;        // no idling in the last part
  int     idle_cycles = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // q2.30 product, floor rounding
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> 30;
  endfunction

  task automatic filter_reset();
    for (int i = 0; i < NumAxes; i++) begin
      ang_q[i] = 0; bias_q[i] = 0; pab[i] = 0; pba[i] = 0;
      paa[i] = 64'sd1 << 30; pbb[i] = 64'sd1 << 30;
    end
    q_angle = AngleNoiseRst; q_bias = BiasNoiseRst;
    r_meas = MeasNoiseRst; dt_q = TimeStepRst;
  endtask

  function automatic fused_t filter_predict(logic ax, logic signed [24:0] meas,
                                            logic signed [27:0] rate);
    fused_t r;
    longint p0, bb0, aa, ab, ba, e, k0, k1, err, m, g;
    m = meas; g = rate;
    r.axis = ax;
    if (ax >= NumAxes) begin
      r.angle = '0; r.rate = '0;
      return r;
    end
    ang_q[ax] = clamp32(ang_q[ax] + qmul(clamp32(g - bias_q[ax]), dt_q));
    p0 = clamp32(q_angle - pab[ax] - pba[ax]);
    bb0 = pbb[ax];
    paa[ax] = clamp32(paa[ax] + qmul(p0, dt_q));
    pab[ax] = clamp32(pab[ax] - qmul(bb0, dt_q));
    pba[ax] = clamp32(pba[ax] - qmul(bb0, dt_q));
    pbb[ax] = clamp32(bb0 + qmul(q_bias, dt_q));
    aa = paa[ax]; ab = pab[ax]; ba = pba[ax];
    e = r_meas + aa;
    if (e > 0) begin
      k0 = clamp32((aa * (64'sd1 << 30)) / e);
      k1 = clamp32((ba * (64'sd1 << 30)) / e);
    end else begin
      k0 = 0; k1 = 0;
    end
    paa[ax] = clamp32(aa - qmul(k0, aa));
    pab[ax] = clamp32(ab - qmul(k0, ab));
    pba[ax] = clamp32(ba - qmul(k1, aa));
    pbb[ax] = clamp32(pbb[ax] - qmul(k1, ab));
    err = clamp32(m - ang_q[ax]);
    ang_q[ax] = clamp32(ang_q[ax] + qmul(k0, err));
    bias_q[ax] = clamp32(bias_q[ax] + qmul(k1, err));
    r.angle = ang_q[ax][31:0];
    r.rate = 32'(clamp32(g - bias_q[ax]));
    return r;
  endfunction

  // idle burst on the input side, valid dropped for its length
  task automatic random_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // send one sample and queue its expected result
  task automatic send_sample(logic ax, logic signed [24:0] meas, logic signed [27:0] rate);
    random_gap();
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ax;
    s_axis_tdata  <= {3'b0, rate, meas};
    do @(posedge clk_i); while (!s_axis_tready);
    fused_expected.push_back(filter_predict(ax, meas, rate));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (fused_expected.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegAngleNoise: q_angle = val;
      RegBiasNoise:  q_bias = val;
      RegMeasNoise:  r_meas = val;
      default:       dt_q = val;
    endcase
  endtask

  task automatic write_all(logic [30:0] qa, logic [30:0] qb, logic [30:0] rm,
                           logic [30:0] dt);
    drain();
    write_reg(RegAngleNoise, qa);
    write_reg(RegBiasNoise, qb);
    write_reg(RegMeasNoise, rm);
    write_reg(RegTimeStep, dt);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [24:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return 25'sd11796480;
      1: return -25'sd11796480;
      default: return $signed(25'($urandom_range(0, 23592960))) - 25'sd11796480;
    endcase
  endfunction

  function automatic logic signed [27:0] rand_rate();
    case ($urandom_range(0, 3))
      0: return 28'sd131072000;
      1: return -28'sd131072000;
      default: return $signed(28'($urandom_range(0, 262144000))) - 28'sd131072000;
    endcase
  endfunction

  // field extremes and both axes at reset settings
  task automatic test_extremes();
    send_sample(1'b0, 25'sd0, 28'sd0);
    send_sample(1'b1, 25'sd11796480, 28'sd131072000);
    send_sample(1'b0, -25'sd11796480, -28'sd131072000);
    send_sample(1'b1, -25'sd11796480, 28'sd131072000);
    send_sample(1'b0, 25'sd11796480, -28'sd131072000);
    send_sample(1'b1, 25'sd65536, 28'sd655360);
  endtask

  // zero process noise and zero time step, then every register at its largest value
  task automatic test_corner_settings();
    write_all(31'd0, 31'd0, 31'd1, 31'd0);
    send_sample(1'b0, 25'sd1000, 28'sd5000);
    send_sample(1'b1, -25'sd1000, -28'sd5000);
    write_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    for (int i = 0; i < 8; i++) send_sample(1'(i), rand_angle(), rand_rate());
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n - 150) calm = 1;
      send_sample(1'($urandom_range(0, 1)), rand_angle(), rand_rate());
    end
  endtask

  // result checker and output stall driver
  always @(posedge clk_i) begin
    fused_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{axis: m_axis_tuser, angle: m_axis_tdata[31:0], rate: m_axis_tdata[63:32]};
      if (fused_expected.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = fused_expected.pop_front();
        if (got.axis !== want.axis) begin
          $display("%0t: axis exp %0d got %0d", $time, want.axis, got.axis);
          errors++;
        end
        if (got.angle !== want.angle) begin
          $display("%0t: angle exp %h got %h", $time, want.angle, got.angle);
          errors++;
        end
        if (got.rate !== want.rate) begin
          $display("%0t: rate exp %h got %h", $time, want.rate, got.rate);
          errors++;
        end
      end
    end
    if (idle_cycles > 0) begin
      idle_cycles <= idle_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      idle_cycles <= $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any transaction
  int stall_count = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_count <= 0;
    end else if (stall_count >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    filter_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_corner_settings();
    write_all(31'd5368709, 31'd8589935, 31'd161061, 31'd8589935);
    test_random(500);
    calm = 0;
    write_all(31'($urandom()), 31'($urandom_range(0, 100000000)),
              31'($urandom_range(1, 50000000)), 31'($urandom_range(1, 50000000)));
    test_random(450);
    calm = 0;
    write_all(31'd1, 31'd1, 31'd1, 31'd1);
    test_random(470);
    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/abkf_pkg.sv
hw/rtl/abkf_mul.sv
hw/rtl/abkf_div.sv
hw/rtl/angle_bias_kalman_filter.sv
tb/angle_bias_kalman_filter_tb.sv
